>>> rtl/core/db_to_color_gradient_macros.svh
// ----------------------------------------------------------------------------
// db_to_color_gradient_macros.svh
// Assertion macros shared by the gradient checker.
// ----------------------------------------------------------------------------
`ifndef DB_TO_COLOR_GRADIENT_MACROS_SVH
`define DB_TO_COLOR_GRADIENT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define DBCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define DBCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that stays armed through reset
`define DBCG_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/dbcg_pkg.sv
// ----------------------------------------------------------------------------
// dbcg_pkg
// Types, color stops and helpers of the dB to color gradient pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dbcg_pkg;

  // Quotient bits of the normalized fraction, one divider stage per bit
  localparam int QW         = 16;
  localparam int DIV_STAGES = QW;
  localparam int SEGMENTS   = 5;

  // Fraction t: 16 fraction bits, 1.0 needs bit 16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_MIN_DB = 2'd0;
  localparam logic [1:0] CFG_MAX_DB = 2'd1;

  // Reset values: -2240 and -640 sixteenths of a dB
  localparam logic [15:0] MIN_DB_RESET = 16'hF740;
  localparam logic [15:0] MAX_DB_RESET = 16'hFD80;

  // Color stops, index 0 is black and index SEGMENTS the top color
  localparam logic [SEGMENTS:0][7:0] STOP_R =
    {8'd235, 8'd235, 8'd40, 8'd10, 8'd8, 8'd0};
  localparam logic [SEGMENTS:0][7:0] STOP_G =
    {8'd40, 8'd220, 8'd200, 8'd120, 8'd8, 8'd0};
  localparam logic [SEGMENTS:0][7:0] STOP_B =
    {8'd30, 8'd40, 8'd90, 8'd180, 8'd90, 8'd0};

  // Channel select
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  // How t is formed once the quotient is known
  typedef enum logic [1:0] {
    T_DIV,
    T_ZERO,
    T_ONE
  } tmode_t;

  // Normalize stage to divider
  typedef struct packed {
    tmode_t      mode;
    logic [15:0] d;
    logic [15:0] span;
  } norm_t;

  // Divider to interpolator
  typedef struct packed {
    tmode_t        mode;
    logic [QW-1:0] quo;
  } quot_t;

  // Channel value of one color stop
  function automatic logic [7:0] stop_chan(input logic [2:0] k, input logic [1:0] ch);
    logic [7:0] v;
    v = 8'd0;
    if (k <= 3'(SEGMENTS)) begin
      case (ch)
        CH_R:    v = STOP_R[k];
        CH_G:    v = STOP_G[k];
        CH_B:    v = STOP_B[k];
        default: v = 8'd0;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dbcg_norm.sv
// ----------------------------------------------------------------------------
// dbcg_norm
// Offsets the magnitude and the range by min_db and sorts out the clamped
// and degenerate cases before the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcg_norm
  import dbcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] magnitude_db,
  input  wire logic [15:0] min_db,
  input  wire logic [15:0] max_db,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      norm_t       out_data
);

  logic signed [16:0] d;
  logic signed [16:0] span;
  logic signed [16:0] d_minus_span;
  norm_t              data_next;

  // Offsets against the bottom of the range
  assign d            = $signed({magnitude_db[15], magnitude_db}) - $signed({min_db[15], min_db});
  assign span         = $signed({max_db[15], max_db}) - $signed({min_db[15], min_db});
  assign d_minus_span = $signed({magnitude_db[15], magnitude_db}) - $signed({max_db[15], max_db});

  // Pick the way t is formed
  always_comb begin
    data_next.d    = d[15:0];
    data_next.span = span[15:0];
    if (span <= 17'sd0) begin
      data_next.mode = d[16] ? T_ZERO : T_ONE;
    end else if (d <= 17'sd0) begin
      data_next.mode = T_ZERO;
    end else if (!d_minus_span[16]) begin
      data_next.mode = T_ONE;
    end else begin
      data_next.mode = T_DIV;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Advance when the stage is empty or drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dbcg_div.sv
// ----------------------------------------------------------------------------
// dbcg_div
// Pipelined restoring divider: t = floor(d * 2^16 / span) for 0 < d < span,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcg_div
  import dbcg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output      logic  in_ready,
  input  wire norm_t in_data,
  output      logic  out_valid,
  input  wire logic  out_ready,
  output      quot_t out_data
);

  typedef struct packed {
    tmode_t        mode;
    logic [15:0]   rem;
    logic [15:0]   span;
    logic [QW-1:0] quo;
  } div_t;

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] rdy;
  div_t                  data [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_t        cur;
    div_t        data_next;
    logic        prev_valid;
    logic        next_ready;
    logic [16:0] rem2;
    logic [16:0] diff;

    // Feed from the input or the previous stage
    if (s == 0) begin : g_first
      assign cur.mode   = in_data.mode;
      assign cur.rem    = in_data.d;
      assign cur.span   = in_data.span;
      assign cur.quo    = '0;
      assign prev_valid = in_valid;
    end else begin : g_mid
      assign cur        = data[s-1];
      assign prev_valid = vld[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_last
      assign next_ready = out_ready;
    end else begin : g_inner
      assign next_ready = rdy[s+1];
    end

    assign rdy[s] = !vld[s] || next_ready;

    // One restoring step: the remainder stays below span
    assign rem2 = {cur.rem, 1'b0};
    assign diff = rem2 - {1'b0, cur.span};

    always_comb begin
      data_next.mode = cur.mode;
      data_next.span = cur.span;
      data_next.quo  = {cur.quo[QW-2:0], !diff[16]};
      data_next.rem  = diff[16] ? rem2[15:0] : diff[15:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= prev_valid;
      end
      if (rdy[s]) begin
        data[s] <= data_next;
      end
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld[DIV_STAGES-1];
  assign out_data.mode = data[DIV_STAGES-1].mode;
  assign out_data.quo  = data[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

>>> rtl/core/dbcg_interp.sv
// ----------------------------------------------------------------------------
// dbcg_interp
// Finds the gradient segment that holds t and interpolates red, green and
// blue between its two stops. Two register stages, the second drives the
// output ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcg_interp
  import dbcg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire quot_t      in_data,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] red,
  output      logic [7:0] green,
  output      logic [7:0] blue
);

  logic        vld1;
  logic        rdy1;
  logic        rdy2;
  logic [16:0] t;
  logic [18:0] t5;
  logic [2:0]  seg_next;
  logic [16:0] u_next;
  logic [2:0]  seg;
  logic [16:0] u;
  logic [7:0]  chan_next [3];

  // Form t from the quotient or the clamped cases
  always_comb begin
    case (in_data.mode)
      T_DIV:   t = {1'b0, in_data.quo};
      T_ONE:   t = ONE_Q16;
      default: t = 17'd0;
    endcase
  end

  assign t5 = {t, 2'b00} + {2'b00, t};

  // Take the first segment whose upper stop is at or above t
  always_comb begin
    seg_next = 3'(SEGMENTS);
    for (int k = SEGMENTS; k >= 1; k--) begin
      if (t5 <= {3'(k), 16'h0000}) begin
        seg_next = 3'(k);
      end
    end
    u_next = 17'(t5 - {seg_next - 3'd1, 16'h0000});
  end

  // Interpolate each channel: a + u * (b - a), keep the integer part
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [7:0]         a;
    logic [7:0]         b;
    logic signed [8:0]  delta;
    logic signed [26:0] prod;
    logic signed [26:0] num;

    assign a     = stop_chan(seg - 3'd1, 2'(c));
    assign b     = stop_chan(seg, 2'(c));
    assign delta = $signed({1'b0, b}) - $signed({1'b0, a});
    assign prod  = $signed({10'b0, u}) * $signed({{18{delta[8]}}, delta});
    assign num   = $signed({3'b000, a, 16'h0000}) + prod;
    assign chan_next[c] = num[23:16];
  end

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  // Segment stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (rdy1) begin
      vld1 <= in_valid;
    end
    if (rdy1) begin
      seg <= seg_next;
      u   <= u_next;
    end
  end

  // Color stage, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= vld1;
    end
    if (rdy2) begin
      red   <= chan_next[0];
      green <= chan_next[1];
      blue  <= chan_next[2];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/db_to_color_gradient.sv
// ----------------------------------------------------------------------------
// db_to_color_gradient
// Maps a spectrum magnitude in dB to an RGB pixel through a five segment
// piecewise linear color gradient.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry magnitude_db (signed, sixteenths of a dB) on
//   in_valid / in_ready; every request gives one pixel on out_valid /
//   out_ready with red, green and blue.
//   min_db and max_db are written on the cfg_valid / cfg_ready channel
//   (cfg_index 0 and 1, other indexes are dropped); cfg_ready is always high.
//   Write them only while no request is in flight.
//   Stages: one normalize stage, sixteen divider stages (one
//   quotient bit each) and two interpolation stages.
//   Throughput is one request per cycle while the receiver does not stall.
//   Each stage advances when it is empty or its successor advances, so a
//   stalled receiver only backs up the pipeline once every stage is full;
//   bubbles are squeezed out and in_ready stays high until then.
//   Reset empties the pipeline and loads min_db = -2240 and max_db = -640.
// ----------------------------------------------------------------------------
`default_nettype none

module db_to_color_gradient
  import dbcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] magnitude_db,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  red,
  output      logic [7:0]  green,
  output      logic [7:0]  blue,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] min_db;
  logic [15:0] max_db;

  logic        norm_valid;
  logic        norm_ready;
  norm_t       norm_data;
  logic        quot_valid;
  logic        quot_ready;
  quot_t       quot_data;

  assign cfg_ready = 1'b1;

  // Range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_db <= MIN_DB_RESET;
      max_db <= MAX_DB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_DB: min_db <= cfg_data;
        CFG_MAX_DB: max_db <= cfg_data;
        default:    ;
      endcase
    end
  end

  dbcg_norm u_norm (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .magnitude_db (magnitude_db),
    .min_db       (min_db),
    .max_db       (max_db),
    .out_valid    (norm_valid),
    .out_ready    (norm_ready),
    .out_data     (norm_data)
  );

  dbcg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_data   (norm_data),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .out_data  (quot_data)
  );

  dbcg_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quot_valid),
    .in_ready  (quot_ready),
    .in_data   (quot_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

`default_nettype wire

>>> rtl/core/dbcg_checker.sv
// ----------------------------------------------------------------------------
// dbcg_checker
// Port level checks of the gradient pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "db_to_color_gradient_macros.svh"

module dbcg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);

  // A draining or empty output stage frees the whole ready chain
  `DBCG_ASSERT_NOW(a_ready_chain, !out_valid || out_ready, in_ready, "in_ready low while output drains")

  // Reset empties the pipeline
  `DBCG_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid, "result left after reset")

  // A stalled result stays offered
  `DBCG_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its color
  `DBCG_ASSERT_NEXT(a_color_hold, out_valid && !out_ready, $stable(red) && $stable(green) && $stable(blue), "color changed while stalled")

endmodule

bind db_to_color_gradient dbcg_checker u_checker (.*);

`default_nettype wire

>>> test/tb_db_to_color_gradient.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_db_to_color_gradient
// Self-checking bench for the dB to color gradient pipeline. A short directed
// table covers range ends, empty and inverted ranges, every color segment and
// the unused register indexes. Random magnitudes then run under eight range
// settings with varied idling and backpressure. Every pixel is compared with
// a fixed color or with a behavioral gradient model kept in the bench.
// ----------------------------------------------------------------------------

module tb_db_to_color_gradient;
  import dbcg_pkg::CFG_MIN_DB;
  import dbcg_pkg::CFG_MAX_DB;
  import dbcg_pkg::MIN_DB_RESET;
  import dbcg_pkg::MAX_DB_RESET;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 150;
  localparam int ITEMS_PER_RANGE = 137;
  localparam longint TIMEOUT_NS = 4_000_000;
  localparam int MAX_PRINTS   = 30;

  // Register indexes the block drops, and a filler index for rows with no write
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [1:0] NO_REG      = 2'd0;

  localparam logic [23:0] BLACK     = 24'h000000;
  localparam logic [23:0] TOP_COLOR = {8'd235, 8'd40, 8'd30};

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PIX_TYPED,
    ROW_PIX_PRED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] val;
    logic [23:0] rgb;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] mag;
    logic [23:0] rgb;
  } pixel_req_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] magnitude_db;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Range registers as the bench believes them
  logic signed [15:0] min_reg;
  logic signed [15:0] max_reg;

  pixel_req_t pending_px[$];
  dir_row_t   dir_rows[$];

  int gap_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int n_mismatch;
  int n_items;
  int n_results;
  int n_cfg;
  int n_stalled;
  int n_settings;

  db_to_color_gradient DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .magnitude_db (magnitude_db),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Color of stop k, black at 0 and the top color at 5
  function automatic logic [23:0] stop_color(input int k);
    case (k)
      0:       return BLACK;
      1:       return {8'd8, 8'd8, 8'd90};
      2:       return {8'd10, 8'd120, 8'd180};
      3:       return {8'd40, 8'd200, 8'd90};
      4:       return {8'd235, 8'd220, 8'd40};
      default: return TOP_COLOR;
    endcase
  endfunction

  // Normalize the magnitude, pick the segment and interpolate each channel
  function automatic logic [23:0] gradient_pixel(input logic signed [15:0] mag,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    longint d, span, t, u, a, b, num;
    int k, c;
    logic [23:0] sa, sb, px;
    d    = longint'(mag) - longint'(lo);
    span = longint'(hi) - longint'(lo);
    // Empty or inverted range: a plain threshold at min_db
    if (span <= 0) begin
      return (d >= 0) ? TOP_COLOR : BLACK;
    end
    if (d <= 0) begin
      t = 0;
    end else if (d >= span) begin
      t = 65536;
    end else begin
      t = (d * 65536) / span;
    end
    k = 1;
    while (t * 5 > longint'(k) * 65536) k++;
    u  = t * 5 - longint'(k - 1) * 65536;
    sa = stop_color(k - 1);
    sb = stop_color(k);
    px = BLACK;
    for (c = 0; c < 3; c++) begin
      a   = longint'(sa[(2 - c) * 8 +: 8]);
      b   = longint'(sb[(2 - c) * 8 +: 8]);
      num = a * 65536 + u * (b - a);
      if (num < 0) num = 0;
      px[(2 - c) * 8 +: 8] = 8'(num / 65536);
    end
    return px;
  endfunction

  // Aim most magnitudes at the displayed range, some at its edges, rest anywhere
  function automatic logic [15:0] pick_mag();
    int lo, hi, span, a, b, r, v;
    lo = min_reg;
    hi = max_reg;
    r  = int'($urandom_range(99));
    if (hi > lo && r < 70) begin
      span = hi - lo;
      a = lo - span / 8;
      b = hi + span / 8;
      if (a < -32768) a = -32768;
      if (b > 32767) b = 32767;
      return 16'(a + int'($urandom_range(b - a)));
    end
    if (r < 85) begin
      v = (((r & 1) != 0) || hi <= lo) ? lo : hi;
      v = v + int'($urandom_range(6)) - 3;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return 16'(v);
    end
    return 16'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] mag,
                                 input logic [23:0] want, input logic [23:0] got);
    if (n_mismatch < MAX_PRINTS)
      $display("%0t ns: %s, magnitude %0d: expected %0h, got %0h",
               $time, what, $signed(mag), want, got);
    n_mismatch++;
  endtask

  // Offer one request, record its expected pixel once accepted
  task automatic send_mag(input logic [15:0] mag, input bit typed,
                          input logic [23:0] want);
    @(negedge clk);
    while (int'($urandom_range(99)) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    magnitude_db <= mag;
    do begin
      @(posedge clk);
      if (!in_ready) n_stalled++;
    end while (!in_ready);
    pending_px.push_back({mag, typed ? want : gradient_pixel(mag, min_reg, max_reg)});
    n_items++;
  endtask

  // Drop valid, wait for every pixel, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MIN_DB) begin
      min_reg = val;
    end else if (idx == CFG_MAX_DB) begin
      max_reg = val;
    end
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= stall_pct);
      end
    end
  end

  // Check each pixel against the oldest pending request
  always @(posedge clk) begin : check_pixels
    pixel_req_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_px.size() == 0) begin
        report_mismatch("pixel with no request pending", 16'h0, BLACK, {red, green, blue});
      end else begin
        want = pending_px.pop_front();
        if (red !== want.rgb[23:16])
          report_mismatch("red mismatch", want.mag, {16'h0, want.rgb[23:16]}, {16'h0, red});
        if (green !== want.rgb[15:8])
          report_mismatch("green mismatch", want.mag, {16'h0, want.rgb[15:8]}, {16'h0, green});
        if (blue !== want.rgb[7:0])
          report_mismatch("blue mismatch", want.mag, {16'h0, want.rgb[7:0]}, {16'h0, blue});
      end
    end
  end

  // Hard stop if the pipeline hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d pixels still pending", pending_px.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main_seq
    int p, s, n, sel, lo, hi;
    dir_row_t row;
    rst          = 1'b1;
    in_valid     = 1'b0;
    magnitude_db = 16'h0;
    cfg_valid    = 1'b0;
    cfg_index    = NO_REG;
    cfg_data     = 16'h0;
    min_reg      = MIN_DB_RESET;
    max_reg      = MAX_DB_RESET;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    hold_left    = 0;
    n_mismatch   = 0;
    n_items      = 0;
    n_results    = 0;
    n_cfg        = 0;
    n_stalled    = 0;
    n_settings   = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset range -2240 .. -640: ends, both sides, one point per segment
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h8000, BLACK});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h7FFF, TOP_COLOR});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'hF740, BLACK});      // -2240
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'hFD80, TOP_COLOR});  // -640
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hF7E0, BLACK});      // -2080
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hF920, BLACK});      // -1760
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hFA60, BLACK});      // -1440
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hFBA0, BLACK});      // -1120
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hFCE0, BLACK});      // -800
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hFD7F, BLACK});      // -641
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hF741, BLACK});      // -2239
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h0000, TOP_COLOR});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'hFFFF, TOP_COLOR});
    // Empty range at 100: threshold only
    dir_rows.push_back({ROW_CFG, CFG_MIN_DB, 16'h0064, BLACK});
    dir_rows.push_back({ROW_CFG, CFG_MAX_DB, 16'h0064, BLACK});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h0064, TOP_COLOR});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h0063, BLACK});
    // Fully inverted range
    dir_rows.push_back({ROW_CFG, CFG_MIN_DB, 16'h7FFF, BLACK});
    dir_rows.push_back({ROW_CFG, CFG_MAX_DB, 16'h8000, BLACK});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h7FFF, TOP_COLOR});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h7FFE, BLACK});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h8000, BLACK});
    // Widest range
    dir_rows.push_back({ROW_CFG, CFG_MIN_DB, 16'h8000, BLACK});
    dir_rows.push_back({ROW_CFG, CFG_MAX_DB, 16'h7FFF, BLACK});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h8000, BLACK});
    dir_rows.push_back({ROW_PIX_TYPED, NO_REG, 16'h7FFF, TOP_COLOR});
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'h0000, BLACK});
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'h5555, BLACK});
    // Unused indexes must leave the range alone
    dir_rows.push_back({ROW_CFG, CFG_SPARE_2, 16'hFFFF, BLACK});
    dir_rows.push_back({ROW_CFG, CFG_SPARE_3, 16'h0000, BLACK});
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'hAAAA, BLACK});
    dir_rows.push_back({ROW_PIX_PRED,  NO_REG, 16'h1234, BLACK});

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.val);
        if (row.idx == CFG_MAX_DB) n_settings++;
      end else begin
        send_mag(row.val, row.kind == ROW_PIX_TYPED, row.rgb);
      end
    end

    // Random part: four idling phases, two range settings each
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 53; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      for (s = 0; s < 2; s++) begin
        sel = 2 * p + s;
        settle();
        case (sel)
          0: begin lo = -2240; hi = -640; end
          1: begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = lo + 1 + int'($urandom_range(7));
            if (hi > 32767) begin
              hi = 32767;
              lo = hi - 8;
            end
          end
          2: begin lo = -32768; hi = 32767; end
          3: begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = lo;
          end
          4: begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = int'($urandom_range(65535)) - 32768;
          end
          5: begin lo = 32767; hi = -32768; end
          6: begin
            lo = -int'($urandom_range(3000));
            hi = lo + 100 + int'($urandom_range(5900));
          end
          default: begin
            lo = -32768;
            hi = int'($urandom_range(65535)) - 32768;
            write_reg(CFG_SPARE_2, 16'($urandom));
            write_reg(CFG_SPARE_3, 16'($urandom));
          end
        endcase
        write_reg(CFG_MIN_DB, 16'(lo));
        write_reg(CFG_MAX_DB, 16'(hi));
        n_settings++;
        for (n = 0; n < ITEMS_PER_RANGE; n++) begin
          // Long receiver hold-off while requests keep coming
          if (sel == 0 && n == 60) hold_req = 1'b1;
          // Sender pause until the pipeline is empty
          if (sel == 7 && n == 68) settle();
          send_mag(pick_mag(), 1'b0, BLACK);
        end
      end
    end

    settle();
    $display("Sent %0d magnitudes over %0d range settings, %0d register writes.",
             n_items, n_settings, n_cfg);
    $display("Checked %0d pixels; input held off for %0d cycles; %0d mismatches.",
             n_results, n_stalled, n_mismatch);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
